// ===== rtl/ahrr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ahrr_pkg
// Shared types, constants and helpers of the HID report reassembler.
// ----------------------------------------------------------------------------
package ahrr_pkg;

    localparam int REPORT_BYTES_DFLT = 64;

    localparam int SEQ_HI_POS        = 3;
    localparam int SEQ_LO_POS        = 4;
    localparam int LEN_HI_POS        = 5;
    localparam int LEN_LO_POS        = 6;
    localparam int FIRST_PAYLOAD_POS = 7;
    localparam int NEXT_PAYLOAD_POS  = 5;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_SEQ  = 2'd1;
    localparam logic [1:0] ERR_LEN  = 2'd2;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] status_word;
        logic        end_of_response;
        logic [1:0]  error_code;
    } t_res_item;

    typedef struct packed {
        logic      valid;
        t_res_item item;
    } t_step_res;

    // Bit 1 is the length error, bit 0 the sequence mismatch.
    function automatic logic [1:0] err_code(input logic [1:0] flags);
        logic [1:0] code;
        if (flags[1]) begin
            code = ERR_LEN;
        end else if (flags[0]) begin
            code = ERR_SEQ;
        end else begin
            code = ERR_NONE;
        end
        return code;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ahrr_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ahrr_if
// Valid/ready channels for report bytes and reassembled response items.
// ----------------------------------------------------------------------------
interface ahrr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] report_byte;

    modport source (output valid, output report_byte, input ready);
    modport sink (input valid, input report_byte, output ready);
endinterface

interface ahrr_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic [15:0] status_word;
    logic        end_of_response;
    logic [1:0]  error_code;

    modport source (output valid, output data_byte, output status_word,
                    output end_of_response, output error_code, input ready);
    modport sink (input valid, input data_byte, input status_word,
                  input end_of_response, input error_code, output ready);
endinterface
`default_nettype wire

// ===== rtl/ahrr_in_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ahrr_in_stage
// Input register that holds one accepted report byte until it is processed.
// ----------------------------------------------------------------------------
module ahrr_in_stage (
    input  wire        i_clk,
    input  wire        i_rst_n,
    ahrr_in_if.sink    i_report,
    input  wire        i_advance,
    output logic       o_step,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;
    logic       accept;

    assign o_step         = r_valid && i_advance;
    assign i_report.ready = !r_valid || i_advance;
    assign accept         = i_report.valid && i_report.ready;
    assign o_byte         = r_byte;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_step) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_report.report_byte;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ahrr_deframer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ahrr_deframer
// Report position tracking, sequence check, length count and status capture.
// ----------------------------------------------------------------------------
module ahrr_deframer import ahrr_pkg::*; #(
    parameter int REPORT_BYTES = REPORT_BYTES_DFLT
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_step,
    input  wire  [7:0] i_byte,
    output t_step_res  o_res
);

    localparam int PosW = $clog2(REPORT_BYTES);

    localparam logic [1:0] PH_FIRST = 2'd0;
    localparam logic [1:0] PH_NEXT  = 2'd1;
    localparam logic [1:0] PH_DRAIN = 2'd2;

    localparam logic [PosW-1:0] LastPos = PosW'(REPORT_BYTES - 1);

    logic [PosW-1:0] r_pos, n_pos;
    logic [15:0]     r_exp_seq, n_exp_seq;
    logic [7:0]      r_seq_hi, n_seq_hi;
    logic [15:0]     r_rem, n_rem;
    logic [7:0]      r_held, n_held;
    logic [1:0]      r_phase, n_phase;
    logic [1:0]      r_eflags, n_eflags;
    logic [15:0]     rem_dec;
    logic [PosW-1:0] payload_pos;

    always_comb begin
        n_pos       = r_pos;
        n_exp_seq   = r_exp_seq;
        n_seq_hi    = r_seq_hi;
        n_rem       = r_rem;
        n_held      = r_held;
        n_phase     = r_phase;
        n_eflags    = r_eflags;
        o_res       = '0;
        rem_dec     = r_rem - 16'd1;
        payload_pos = (r_phase == PH_FIRST) ? PosW'(FIRST_PAYLOAD_POS)
                                            : PosW'(NEXT_PAYLOAD_POS);

        if (r_phase == PH_FIRST && r_pos == '0) begin
            n_eflags  = 2'b00;
            n_exp_seq = 16'd0;
            n_rem     = 16'd0;
        end

        if (r_phase != PH_DRAIN) begin
            if (r_pos == PosW'(SEQ_HI_POS)) begin
                n_seq_hi = i_byte;
            end else if (r_pos == PosW'(SEQ_LO_POS)) begin
                if ({r_seq_hi, i_byte} != n_exp_seq) begin
                    n_eflags[0] = 1'b1;
                end
                n_exp_seq = n_exp_seq + 16'd1;
            end else if (r_phase == PH_FIRST && r_pos == PosW'(LEN_HI_POS)) begin
                n_rem = {i_byte, 8'd0};
            end else if (r_phase == PH_FIRST && r_pos == PosW'(LEN_LO_POS)) begin
                n_rem = {r_rem[15:8], i_byte};
                if (n_rem < 16'd2) begin
                    n_eflags[1]                = 1'b1;
                    n_rem                      = 16'd0;
                    o_res.valid                = 1'b1;
                    o_res.item.end_of_response = 1'b1;
                    o_res.item.error_code      = err_code(n_eflags);
                    n_phase                    = PH_DRAIN;
                end
            end else if (r_pos >= payload_pos && r_rem != 16'd0) begin
                n_rem = rem_dec;
                if (rem_dec >= 16'd2) begin
                    o_res.valid           = 1'b1;
                    o_res.item.data_byte  = i_byte;
                    o_res.item.error_code = err_code(n_eflags);
                end else if (rem_dec == 16'd1) begin
                    n_held = i_byte;
                end else begin
                    o_res.valid                = 1'b1;
                    o_res.item.status_word     = {r_held, i_byte};
                    o_res.item.end_of_response = 1'b1;
                    o_res.item.error_code      = err_code(n_eflags);
                    n_phase                    = PH_DRAIN;
                end
            end
        end

        if (r_pos == LastPos) begin
            n_pos = '0;
            if (n_phase == PH_DRAIN) begin
                n_phase = PH_FIRST;
            end else if (n_phase == PH_FIRST) begin
                n_phase = PH_NEXT;
            end
        end else begin
            n_pos = r_pos + PosW'(1);
        end

        o_res.valid = o_res.valid && i_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_exp_seq <= 16'd0;
            r_seq_hi  <= 8'd0;
            r_rem     <= 16'd0;
            r_held    <= 8'd0;
            r_phase   <= PH_FIRST;
            r_eflags  <= 2'b00;
        end else if (i_step) begin
            r_pos     <= n_pos;
            r_exp_seq <= n_exp_seq;
            r_seq_hi  <= n_seq_hi;
            r_rem     <= n_rem;
            r_held    <= n_held;
            r_phase   <= n_phase;
            r_eflags  <= n_eflags;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ahrr_out_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ahrr_out_stage
// Result register that presents one response item to the receiver.
// ----------------------------------------------------------------------------
module ahrr_out_stage import ahrr_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_step_res  i_res,
    ahrr_out_if.source o_resp,
    output logic       o_free
);

    logic      r_valid;
    logic      n_valid;
    t_res_item r_item;

    assign o_free = !r_valid || o_resp.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_res.valid) begin
            n_valid = 1'b1;
        end else if (o_resp.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res.valid) begin
            r_item <= i_res.item;
        end
    end

    assign o_resp.valid           = r_valid;
    assign o_resp.data_byte       = r_item.data_byte;
    assign o_resp.status_word     = r_item.status_word;
    assign o_resp.end_of_response = r_item.end_of_response;
    assign o_resp.error_code      = r_item.error_code;

endmodule
`default_nettype wire

// ===== rtl/apdu_hid_report_reassembler_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// apdu_hid_report_reassembler_unit
// Recovers one response from a stream of fixed-size transport report bytes.
// ----------------------------------------------------------------------------
// The report channel takes one byte per transaction, reports of REPORT_BYTES
// bytes back to back. The response channel gives one item per transaction: a
// payload byte, or a closing item with end_of_response set and the status word
// (zero on a length error), each with the error code seen so far in the response.
// An accepted byte is processed while it sits in the input register, and its
// result, if any, is registered in the result register as the byte leaves;
// the response channel offers it from there. The block takes one byte every
// cycle while the receiver keeps up, since the report position, sequence and
// length updates are combinational.
// When the receiver stalls with a result pending, the input register holds
// the next byte and the report channel accepts one more byte at most.
// Reset empties both registers and waits for the first report of a response.
// ----------------------------------------------------------------------------
module apdu_hid_report_reassembler_unit import ahrr_pkg::*; #(
    parameter int REPORT_BYTES = REPORT_BYTES_DFLT
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    ahrr_in_if.sink    i_report,
    ahrr_out_if.source o_resp
);

    logic       out_free;
    logic       step;
    logic [7:0] in_byte;
    t_step_res  step_res;

    ahrr_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_report  (i_report),
        .i_advance (out_free),
        .o_step    (step),
        .o_byte    (in_byte)
    );

    ahrr_deframer #(
        .REPORT_BYTES (REPORT_BYTES)
    ) u_deframer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (in_byte),
        .o_res   (step_res)
    );

    ahrr_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (step_res),
        .o_resp  (o_resp),
        .o_free  (out_free)
    );

`ifndef SYNTH
    a_eor_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_resp.valid && o_resp.end_of_response |-> o_resp.data_byte == 8'd0)
        else $error("closing item carries a data byte");

    a_data_no_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_resp.valid && !o_resp.end_of_response |-> o_resp.status_word == 16'd0)
        else $error("data item carries a status word");

    a_len_err_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_resp.valid && o_resp.error_code == ERR_LEN |->
            o_resp.end_of_response && o_resp.status_word == 16'd0)
        else $error("length error item is not a closing item");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_resp.valid |-> o_resp.error_code == ERR_NONE ||
            o_resp.error_code == ERR_SEQ || o_resp.error_code == ERR_LEN)
        else $error("undefined error code on the response channel");
`endif

endmodule
`default_nettype wire

// ===== bench/apdu_hid_report_reassembler_unit_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// apdu_hid_report_reassembler_unit_tb
// Self-checking testbench of the HID report reassembler.
// ----------------------------------------------------------------------------
// Whole 64-byte transport reports are fed into the report channel, and every
// accepted byte is run through a deframer model kept in the testbench. Each
// response item that the block gives out is compared field by field with the
// oldest predicted item. Directed tests cover status-only and one-byte
// responses, short length errors, report-boundary endings and long responses
// with sequence faults. Random tests mix well-formed responses with cut-off
// responses and raw bytes, while both channels idle at random and the
// receiver once holds off long enough to stall the report channel.
// ----------------------------------------------------------------------------
module apdu_hid_report_reassembler_unit_tb;
    import ahrr_pkg::*;

    localparam int RB          = REPORT_BYTES_DFLT;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 16;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_NEXT,
        PH_DRAIN
    } t_rx_phase;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ahrr_in_if  rpt_ch ();
    ahrr_out_if rsp_ch ();

    apdu_hid_report_reassembler_unit #(
        .REPORT_BYTES(RB)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_report(rpt_ch),
        .o_resp  (rsp_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Deframer state as seen by the testbench.
    int          rx_pos;
    t_rx_phase   rx_phase;
    logic [15:0] seq_expected;
    logic [7:0]  seq_hi_rx;
    logic [15:0] length_left;
    logic [7:0]  status_hi;
    logic [1:0]  err_flags;

    t_res_item   pending_resp_items[$];
    int          error_count = 0;
    int          bytes_sent = 0;
    bit          sender_idles = 1'b1;
    bit          receiver_idles = 1'b1;
    logic        hold_off;

    task automatic deframe_byte(input logic [7:0] b);
        t_res_item item;
        logic      emit;
        item = '0;
        emit = 1'b0;
        if (rx_phase == PH_FIRST && rx_pos == 0) begin
            err_flags = 2'b00;
            seq_expected = '0;
            length_left = '0;
        end
        if (rx_phase != PH_DRAIN) begin
            if (rx_pos == SEQ_HI_POS) begin
                seq_hi_rx = b;
            end else if (rx_pos == SEQ_LO_POS) begin
                if ({seq_hi_rx, b} != seq_expected) begin
                    err_flags[0] = 1'b1;
                end
                seq_expected = seq_expected + 16'd1;
            end else if (rx_phase == PH_FIRST && rx_pos == LEN_HI_POS) begin
                length_left = {b, 8'h00};
            end else if (rx_phase == PH_FIRST && rx_pos == LEN_LO_POS) begin
                length_left[7:0] = b;
                if (length_left < 16'd2) begin
                    err_flags[1] = 1'b1;
                    length_left = '0;
                    item.end_of_response = 1'b1;
                    emit = 1'b1;
                    rx_phase = PH_DRAIN;
                end
            end else if (rx_pos >= (rx_phase == PH_FIRST ? FIRST_PAYLOAD_POS : NEXT_PAYLOAD_POS)
                         && length_left != 16'd0) begin
                length_left = length_left - 16'd1;
                if (length_left >= 16'd2) begin
                    item.data_byte = b;
                    emit = 1'b1;
                end else if (length_left == 16'd1) begin
                    status_hi = b;
                end else begin
                    item.status_word = {status_hi, b};
                    item.end_of_response = 1'b1;
                    emit = 1'b1;
                    rx_phase = PH_DRAIN;
                end
            end
        end
        if (rx_pos == RB - 1) begin
            rx_pos = 0;
            if (rx_phase == PH_DRAIN) begin
                rx_phase = PH_FIRST;
            end else if (rx_phase == PH_FIRST) begin
                rx_phase = PH_NEXT;
            end
        end else begin
            rx_pos = rx_pos + 1;
        end
        if (emit) begin
            item.error_code = err_flags[1] ? ERR_LEN : (err_flags[0] ? ERR_SEQ : ERR_NONE);
            pending_resp_items = {pending_resp_items, item};
        end
    endtask

    task automatic send_report_byte(input logic [7:0] value);
        int gap;
        gap = sender_idles ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            rpt_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rpt_ch.valid <= 1'b1;
        rpt_ch.report_byte <= value;
        do @(posedge i_clk); while (!rpt_ch.ready);
        deframe_byte(value);
        bytes_sent++;
    endtask

    // A bad_report of -1 keeps every sequence number right; a cut_after of 0
    // sends all reports that the length needs; a fill of -1 gives random bytes.
    task automatic send_response(input logic [15:0] resp_len, input int bad_report,
                                 input int cut_after, input int fill);
        int          n_reports;
        int          rep;
        int          p;
        logic [15:0] seq_no;
        logic [7:0]  value;
        if (resp_len <= RB - FIRST_PAYLOAD_POS) begin
            n_reports = 1;
        end else begin
            n_reports = 1 + (int'(resp_len) - (RB - FIRST_PAYLOAD_POS)
                             + RB - NEXT_PAYLOAD_POS - 1) / (RB - NEXT_PAYLOAD_POS);
        end
        if (cut_after > 0 && cut_after < n_reports) begin
            n_reports = cut_after;
        end
        for (rep = 0; rep < n_reports; rep++) begin
            seq_no = rep[15:0];
            if (rep == bad_report) begin
                seq_no = seq_no ^ (16'h1 << $urandom_range(0, 15));
            end
            for (p = 0; p < RB; p++) begin
                if (p == SEQ_HI_POS) begin
                    value = seq_no[15:8];
                end else if (p == SEQ_LO_POS) begin
                    value = seq_no[7:0];
                end else if (rep == 0 && p == LEN_HI_POS) begin
                    value = resp_len[15:8];
                end else if (rep == 0 && p == LEN_LO_POS) begin
                    value = resp_len[7:0];
                end else if (fill >= 0 && p >= NEXT_PAYLOAD_POS) begin
                    value = fill[7:0];
                end else begin
                    value = 8'($urandom);
                end
                send_report_byte(value);
            end
        end
    endtask

    task automatic test_status_word_only;
        send_response(16'd2, -1, 0, 8'hFF);
        send_response(16'd3, -1, 0, -1);
    endtask

    task automatic test_length_errors;
        send_response(16'd0, -1, 0, -1);
        send_response(16'd1, 0, 0, -1);
    endtask

    task automatic test_report_boundary;
        send_response(16'(RB - FIRST_PAYLOAD_POS), -1, 0, 8'h00);
        send_response(16'(RB - FIRST_PAYLOAD_POS + 1), -1, 0, 8'hFF);
    endtask

    task automatic test_long_response;
        send_response(16'h0080, 2, 0, -1);
    endtask

    task automatic test_backpressure;
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off <= 1'b0;
            end
        join_none
        send_response(16'd50, -1, 0, -1);
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
    endtask

    task automatic test_random_responses(input int n_bytes);
        int start;
        int pick;
        int bad;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            sender_idles = $urandom_range(0, 3) != 0;
            receiver_idles = $urandom_range(0, 3) != 0;
            pick = $urandom_range(0, 99);
            bad = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 4) : -1;
            if (pick < 55) begin
                send_response(16'($urandom_range(2, RB - FIRST_PAYLOAD_POS)), bad, 0, -1);
            end else if (pick < 78) begin
                send_response(16'($urandom_range(RB - FIRST_PAYLOAD_POS + 1, 300)), bad, 0, -1);
            end else if (pick < 85) begin
                send_response(16'($urandom_range(0, 1)), bad, 0, -1);
            end else if (pick < 93) begin
                send_response(16'($urandom_range(RB, 400)), bad, 1, -1);
            end else begin
                send_response(16'($urandom_range(0, 511)), $urandom_range(0, 1) - 1, 0, -1);
            end
        end
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
    endtask

    task automatic test_raw_noise;
        int k;
        for (k = 0; k < RB; k++) begin
            send_report_byte(8'($urandom));
        end
    endtask

    initial begin
        int        stall_left;
        t_res_item got;
        t_res_item want;
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_ch.valid && rsp_ch.ready) begin
                got.data_byte = rsp_ch.data_byte;
                got.status_word = rsp_ch.status_word;
                got.end_of_response = rsp_ch.end_of_response;
                got.error_code = rsp_ch.error_code;
                if (pending_resp_items.size() == 0) begin
                    $error("Response item %p arrived with nothing expected.", got);
                    error_count++;
                end else begin
                    want = pending_resp_items.pop_front();
                    if (got.data_byte !== want.data_byte) begin
                        $error("data_byte: expected %0h, got %0h", want.data_byte,
                               got.data_byte);
                        error_count++;
                    end
                    if (got.status_word !== want.status_word) begin
                        $error("status_word: expected %0h, got %0h", want.status_word,
                               got.status_word);
                        error_count++;
                    end
                    if (got.end_of_response !== want.end_of_response) begin
                        $error("end_of_response: expected %0b, got %0b",
                               want.end_of_response, got.end_of_response);
                        error_count++;
                    end
                    if (got.error_code !== want.error_code) begin
                        $error("error_code: expected %0d, got %0d", want.error_code,
                               got.error_code);
                        error_count++;
                    end
                end
                stall_left = receiver_idles ? $urandom_range(0, 6) : 0;
            end
            if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_ch.ready <= !hold_off;
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((rpt_ch.valid && rpt_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        rx_pos = 0;
        rx_phase = PH_FIRST;
        seq_expected = '0;
        seq_hi_rx = '0;
        length_left = '0;
        status_hi = '0;
        err_flags = 2'b00;
        i_rst_n <= 1'b0;
        hold_off <= 1'b0;
        rpt_ch.valid <= 1'b0;
        rpt_ch.report_byte <= 8'h00;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_status_word_only();
        test_length_errors();
        test_report_boundary();
        test_long_response();
        test_backpressure();
        test_random_responses(120);
        test_raw_noise();

        rpt_ch.valid <= 1'b0;
        while (pending_resp_items.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/ahrr_pkg.sv
rtl/ahrr_if.sv
rtl/ahrr_in_stage.sv
rtl/ahrr_deframer.sv
rtl/ahrr_out_stage.sv
rtl/apdu_hid_report_reassembler_unit.sv
bench/apdu_hid_report_reassembler_unit_tb.sv
